/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_REMOVE,
      STATE_SCAN,
      STATE_FRONT
   } state_type;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

/* rtl/stable_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue kept sorted in one memory, highest priority first,
// entries of equal priority in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   req_action selects insert or remove; req_item_value and req_item_priority
//   are used by an insert only. Every request yields exactly one response
//   beat, shown for one cycle with rsp_valid high; the receiver cannot stall.
// Operation:
//   Refused insert (full), remove from an empty queue and insert into an
//   empty queue: the response appears in the cycle after the request.
//   Remove: one memory read of the front entry, answered from STATE_REMOVE.
//   Insert into n entries: the scan walks back from the tail one entry per
//   cycle through the memory's read port, moving each lower-priority entry
//   up by one, and stops behind the first entry of equal or higher
//   priority; if there is none, STATE_FRONT writes the new entry in front.
//   busy is high while an item is in progress; the next request can be taken
//   in the cycle its response is shown.
// Reset:
//   Synchronous reset empties the queue at once; the memory contents are
//   left as they are, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
   parameter int CAPACITY      = 16,
   parameter int VALUE_BITS    = 16,
   parameter int PRIORITY_BITS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [VALUE_BITS-1:0]              req_item_value,
   input  logic [PRIORITY_BITS-1:0]           req_item_priority,
   output logic                               rsp_valid,
   output logic [VALUE_BITS-1:0]              rsp_out_value,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_occupancy
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = PRIORITY_BITS + VALUE_BITS;

   spq_pkg::state_type state_ff, state_in;

   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            scan_ff, scan_in;
   logic [VALUE_BITS-1:0]    new_value_ff, new_value_in;
   logic [PRIORITY_BITS-1:0] new_prio_ff, new_prio_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [CW-1:0]            rsp_occ_ff, rsp_occ_in;

   // Entry memory: priority in the upper bits, value in the lower bits.
   logic [EW-1:0]            entry_mem [CAPACITY];
   logic [EW-1:0]            rd_data_ff;
   logic                     mem_we;
   logic [AW-1:0]            wr_logical, rd_logical;
   logic [EW-1:0]            mem_wdata;

   logic                     accept;
   logic                     is_full;
   logic [VALUE_BITS-1:0]    rd_value;
   logic [PRIORITY_BITS-1:0] rd_prio;
   logic                     stop_here;

   // Logical position from the front to a physical memory address.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] lg);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, lg};
      if (sum >= (AW+1)'(CAPACITY)) begin
         sum = sum - (AW+1)'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   assign accept    = start && !busy;
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign rd_value  = rd_data_ff[VALUE_BITS-1:0];
   assign rd_prio   = rd_data_ff[VALUE_BITS +: PRIORITY_BITS];
   assign stop_here = (rd_prio >= new_prio_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::STATE_IDLE: begin
            if (accept) begin
               if (req_action == spq_pkg::ACTION_REMOVE) begin
                  if (count_ff != '0) begin
                     state_in = spq_pkg::STATE_REMOVE;
                  end
               end else if (!is_full && count_ff != '0) begin
                  state_in = spq_pkg::STATE_SCAN;
               end
            end
         end
         spq_pkg::STATE_REMOVE: begin
            state_in = spq_pkg::STATE_IDLE;
         end
         spq_pkg::STATE_SCAN: begin
            if (stop_here) begin
               state_in = spq_pkg::STATE_IDLE;
            end else if (scan_ff == '0) begin
               state_in = spq_pkg::STATE_FRONT;
            end
         end
         spq_pkg::STATE_FRONT: begin
            state_in = spq_pkg::STATE_IDLE;
         end
         default: begin
            state_in = spq_pkg::STATE_IDLE;
         end
      endcase
   end

   // Datapath, memory control and response.
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      new_value_in  = new_value_ff;
      new_prio_in   = new_prio_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = spq_pkg::STATUS_DONE;
      rsp_occ_in    = count_ff;
      mem_we        = 1'b0;
      wr_logical    = '0;
      rd_logical    = scan_ff;
      mem_wdata     = {new_prio_ff, new_value_ff};
      case (state_ff)
         spq_pkg::STATE_IDLE: begin
            if (accept) begin
               if (req_action == spq_pkg::ACTION_REMOVE) begin
                  rd_logical = '0;
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = spq_pkg::STATUS_EMPTY;
                  end
               end else if (is_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = spq_pkg::STATUS_FULL;
               end else if (count_ff == '0) begin
                  mem_we       = 1'b1;
                  mem_wdata    = {req_item_priority, req_item_value};
                  count_in     = CW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_occ_in   = CW'(1);
               end else begin
                  // Start the scan at the tail entry.
                  rd_logical   = AW'(count_ff - 1'b1);
                  scan_in      = AW'(count_ff - 1'b1);
                  new_value_in = req_item_value;
                  new_prio_in  = req_item_priority;
               end
            end
         end
         spq_pkg::STATE_REMOVE: begin
            head_in       = (head_ff == AW'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
            count_in      = count_ff - 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_value;
            rsp_occ_in    = count_ff - 1'b1;
         end
         spq_pkg::STATE_SCAN: begin
            mem_we     = 1'b1;
            wr_logical = scan_ff + 1'b1;
            if (stop_here) begin
               count_in     = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_occ_in   = count_ff + 1'b1;
            end else begin
               // Move the lower-priority entry up by one and keep walking.
               mem_wdata = rd_data_ff;
               if (scan_ff != '0) begin
                  rd_logical = scan_ff - 1'b1;
                  scan_in    = scan_ff - 1'b1;
               end
            end
         end
         spq_pkg::STATE_FRONT: begin
            mem_we       = 1'b1;
            wr_logical   = '0;
            count_in     = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_occ_in   = count_ff + 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[phys(head_ff, wr_logical)] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[phys(head_ff, rd_logical)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::STATE_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      new_value_ff  <= new_value_in;
      new_prio_ff   <= new_prio_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign busy          = (state_ff != spq_pkg::STATE_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

`ifndef SYNTH
   // The count never runs past the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   // A remove taken while empty answers in the next cycle with the empty code.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == spq_pkg::ACTION_REMOVE && count_ff == '0)
      |=> (rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY))
      else $error("empty remove not answered");

   // A refused insert reports a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == spq_pkg::STATUS_FULL)
      |-> (rsp_occupancy == CW'(CAPACITY)))
      else $error("full status with queue not full");

   // The scan writes only within the entries held plus the new slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == spq_pkg::STATE_SCAN) |-> ({1'b0, scan_ff} < CW'(count_ff)))
      else $error("scan position outside held entries");
`endif

endmodule

/* bench/spq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches the request and response channels of the priority queue core. It
// keeps its own sorted copy of the queue and, for each request taken, works
// out the response owed. Each response beat is compared field by field with
// the oldest response owed.
// ----------------------------------------------------------------------------
module spq_checker #(
   parameter int CAPACITY      = 16,
   parameter int VALUE_BITS    = 16,
   parameter int PRIORITY_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_action,
   input  logic [VALUE_BITS-1:0]         req_item_value,
   input  logic [PRIORITY_BITS-1:0]      req_item_priority,
   input  logic                          rsp_valid,
   input  logic [VALUE_BITS-1:0]         rsp_out_value,
   input  logic [1:0]                    rsp_status,
   input  logic [$clog2(CAPACITY+1)-1:0] rsp_occupancy,
   output int                            failures,
   output int                            pending
);

   localparam int OCC_BITS = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [1:0]            status;
      logic [OCC_BITS-1:0]   occupancy;
   } response_type;

   // Index 0 holds the entry that leaves next.
   logic [VALUE_BITS-1:0]    held_values [CAPACITY];
   logic [PRIORITY_BITS-1:0] held_prios  [CAPACITY];
   int                       held_count;
   response_type             owed_responses [$];
   response_type             owed;

   function automatic response_type serve_request(input logic action,
                                                  input logic [VALUE_BITS-1:0] value,
                                                  input logic [PRIORITY_BITS-1:0] prio);
      response_type resp;
      int           slot;
      resp = '0;
      resp.status = spq_pkg::STATUS_DONE;
      if (action == spq_pkg::ACTION_INSERT) begin
         if (held_count >= CAPACITY) begin
            resp.status = spq_pkg::STATUS_FULL;
         end else begin
            // The new entry goes behind every entry of equal or higher priority.
            slot = 0;
            while (slot < held_count && held_prios[slot] >= prio) slot++;
            for (int k = held_count; k > slot; k--) begin
               held_values[k] = held_values[k-1];
               held_prios[k]  = held_prios[k-1];
            end
            held_values[slot] = value;
            held_prios[slot]  = prio;
            held_count++;
         end
      end else if (held_count == 0) begin
         resp.status = spq_pkg::STATUS_EMPTY;
      end else begin
         resp.value = held_values[0];
         for (int k = 1; k < held_count; k++) begin
            held_values[k-1] = held_values[k];
            held_prios[k-1]  = held_prios[k];
         end
         held_count--;
      end
      resp.occupancy = OCC_BITS'(held_count);
      return resp;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         owed_responses.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_responses.size() == 0) begin
               $display("%0t: unexpected response beat: value %h status %0d occupancy %0d",
                        $time, rsp_out_value, rsp_status, rsp_occupancy);
               failures++;
            end else begin
               owed = owed_responses.pop_front();
               if (rsp_out_value !== owed.value) begin
                  $display("%0t: out_value expected %h, got %h",
                           $time, owed.value, rsp_out_value);
                  failures++;
               end
               if (rsp_status !== owed.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, owed.status, rsp_status);
                  failures++;
               end
               if (rsp_occupancy !== owed.occupancy) begin
                  $display("%0t: occupancy expected %0d, got %0d",
                           $time, owed.occupancy, rsp_occupancy);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            owed_responses.push_back(serve_request(req_action, req_item_value,
                                                   req_item_priority));
         end
      end
      pending = owed_responses.size();
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the stable priority queue core with a directed run through the edge
// cases (empty remove, full insert, ties, extreme values) and then with
// random bursts whose insert/remove mix sweeps the queue between empty and
// full. Requests are spaced by random gaps; the checker scores every response.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CAPACITY      = 16;
   localparam int VALUE_BITS    = 16;
   localparam int PRIORITY_BITS = 4;
   localparam int OCC_BITS      = $clog2(CAPACITY + 1);
   localparam int RANDOM_ITEMS  = 1000;
   localparam int CYCLE_LIMIT   = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_action = spq_pkg::ACTION_INSERT;
   logic [VALUE_BITS-1:0]    req_item_value = '0;
   logic [PRIORITY_BITS-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   logic [VALUE_BITS-1:0]    rsp_out_value;
   logic [1:0]               rsp_status;
   logic [OCC_BITS-1:0]      rsp_occupancy;
   int                       failures;
   int                       pending;
   int                       cycle_count = 0;
   bit                       gaps_enabled = 1'b1;

   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   stable_priority_queue_core #(
      .CAPACITY      (CAPACITY),
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   spq_checker #(
      .CAPACITY      (CAPACITY),
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) response_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .failures          (failures),
      .pending           (pending)
   );

   // Holds one request beat on the inputs until the core takes it.
   task automatic issue(input logic action, input logic [VALUE_BITS-1:0] value,
                        input logic [PRIORITY_BITS-1:0] prio);
      @(negedge clock);
      start             <= 1'b1;
      req_action        <= action;
      req_item_value    <= value;
      req_item_priority <= prio;
      do @(posedge clock); while (busy);
   endtask

   // Idle time after a beat: mostly none, sometimes short, now and then long.
   task automatic idle_gap();
      int pick;
      int gap;
      pick = $urandom_range(99);
      if (!gaps_enabled || pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 8);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int sent;
      int burst;
      int insert_pct;
      bit narrow_prio;
      logic action;
      logic [PRIORITY_BITS-1:0] prio;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty remove, extremes, ties, fill up, refused insert.
      issue(spq_pkg::ACTION_REMOVE, 16'hFFFF, 4'hF);
      idle_gap();
      issue(spq_pkg::ACTION_INSERT, 16'hFFFF, 4'hF);
      idle_gap();
      issue(spq_pkg::ACTION_INSERT, 16'h0000, 4'h0);
      idle_gap();
      issue(spq_pkg::ACTION_INSERT, 16'h1234, 4'h7);
      idle_gap();
      issue(spq_pkg::ACTION_INSERT, 16'h5678, 4'h7);
      idle_gap();
      issue(spq_pkg::ACTION_INSERT, 16'hAAAA, 4'hF);
      idle_gap();
      issue(spq_pkg::ACTION_INSERT, 16'h5555, 4'h0);
      idle_gap();
      for (int i = 0; i < CAPACITY - 6; i++) begin
         issue(spq_pkg::ACTION_INSERT, VALUE_BITS'(16'h0100 + i),
               PRIORITY_BITS'((i * 5) % 16));
         idle_gap();
      end
      issue(spq_pkg::ACTION_INSERT, 16'hBEEF, 4'hF);
      idle_gap();
      repeat (3) begin
         issue(spq_pkg::ACTION_REMOVE, 16'h0000, 4'h0);
         idle_gap();
      end

      // Random bursts, each with its own insert/remove mix and gap behavior.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst        = $urandom_range(60, 10);
         case ($urandom_range(2))
            0: insert_pct = 15;
            1: insert_pct = 50;
            default: insert_pct = 85;
         endcase
         narrow_prio  = 1'($urandom_range(1));
         gaps_enabled = ($urandom_range(3) != 0);
         repeat (burst) begin
            action = ($urandom_range(99) < insert_pct) ? spq_pkg::ACTION_INSERT
                                                       : spq_pkg::ACTION_REMOVE;
            // A narrow priority band makes ties common.
            prio = narrow_prio ? PRIORITY_BITS'($urandom_range(8, 6))
                               : PRIORITY_BITS'($urandom);
            issue(action, VALUE_BITS'($urandom), prio);
            idle_gap();
            sent++;
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait (pending == 0);
      repeat (CAPACITY + 4) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
